>>> sv/lcpe_pkg.sv
// Shared types, constants and the segment table of the LED command packet encoder.
package lcpe_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int WORD_W      = 28;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int DIGITS_W    = NIB_W * DIGIT_COUNT;

    // Field positions inside the LED word.
    localparam int EN_LSB = 16;
    localparam int DP_LSB = 24;

    localparam logic [BYTE_W-1:0] DP_FLAG = 8'h10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_OPCODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_MODE_OPCODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_SET_OPCODE   = 2'd2;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_SET    = 2'd1,
        OP_REPLAY = 2'd2
    } op_t;

    // Header bytes still owed by a set sequence, counted down.
    localparam logic [1:0] HDR_USER = 2'd3;
    localparam logic [1:0] HDR_SET  = 2'd2;
    localparam logic [1:0] HDR_MASK = 2'd1;
    localparam logic [1:0] HDR_NONE = 2'd0;

    // One classified command as it waits for the back end.
    typedef struct packed {
        logic                   init_left;
        logic [1:0]             hdr_left;
        logic [DIGIT_COUNT-1:0] dig_left;
        logic [DIGIT_COUNT-1:0] en;
        logic [DIGIT_COUNT-1:0] points;
        logic [DIGITS_W-1:0]    digits;
    } desc_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] init_opcode;
        logic [BYTE_W-1:0] user_mode_opcode;
        logic [BYTE_W-1:0] led_set_opcode;
    } cfg_regs_t;

    function automatic logic [BYTE_W-1:0] seg_code(input logic [NIB_W-1:0] nib);
        logic [BYTE_W-1:0] code;
        case (nib)
            4'h0: code = 8'hE7;
            4'h1: code = 8'h06;
            4'h2: code = 8'hCB;
            4'h3: code = 8'h8F;
            4'h4: code = 8'h2E;
            4'h5: code = 8'hAD;
            4'h6: code = 8'hED;
            4'h7: code = 8'h86;
            4'h8: code = 8'hEF;
            4'h9: code = 8'hAF;
            4'hA: code = 8'hEE;
            4'hB: code = 8'h6D;
            4'hC: code = 8'hE1;
            4'hD: code = 8'h4F;
            4'hE: code = 8'hE9;
            4'hF: code = 8'hE8;
            default: code = 8'hE7;
        endcase
        return code;
    endfunction

endpackage

>>> sv/led_command_packet_encoder_core.sv
// Top level of the LED command packet encoder: front end, descriptor queue and byte sender.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_op[1:0], s_led_word[27:0]
//  m_        out        m_valid/m_ready    m_out_byte[7:0], m_last
//  cfg_      in         cfg_wr_en          cfg_index[1:0], cfg_wdata[7:0]
//
// A command produces one output byte for init, three plus the number of enabled digits
// for set LEDs, and four plus that for replay (up to eight).
// The byte sender sets the rate; when the next command is already queued, it moves from
// one command's last byte straight to the next command's first byte with no gap.
// Reset is synchronous and active low; it clears the opcodes, the saved LED word,
// the queue and the output valid flag.
// A stalled output holds its byte while the two-entry queue takes requests until full.
module led_command_packet_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [27:0] s_led_word,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    logic                q_push;
    logic                q_pop;
    lcpe_pkg::desc_t     q_push_desc;
    lcpe_pkg::desc_t     q_head_desc;
    lcpe_pkg::q_status_t q_status;
    logic                s_accept;

    // A request is taken whenever the queue has room; the unused op code is
    // taken too but never reaches the queue.
    assign s_ready  = !q_status.full;
    assign s_accept = s_valid && s_ready;

    // The front end classifies each request into a descriptor that says which
    // bytes are owed: the init opcode, the three header bytes of a set packet,
    // and a bit per enabled digit. Set requests update the saved word here.
    lcpe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .op        (s_op),
        .led_word  (s_led_word),
        .push      (q_push),
        .push_desc (q_push_desc)
    );

    lcpe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_push_desc),
        .pop       (q_pop),
        .head_desc (q_head_desc),
        .status    (q_status)
    );

    // The back end works the head descriptor down one byte per cycle, while the output
    // is not stalled, into its output register. The first byte of a queued descriptor is
    // registered in the same cycle the descriptor is popped.
    lcpe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .head_desc  (q_head_desc),
        .q_status   (q_status),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

`ifndef NO_ASSERTIONS
    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("descriptor queue written while full");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_status.head_valid)
        else $error("descriptor queue popped while empty");

    // Bytes of one command follow each other with no gap.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("gap inside a command's byte sequence");
`endif

endmodule

>>> sv/lcpe_front.sv
// Front end: takes commands, keeps the saved LED word and builds byte-sequence descriptors.
module lcpe_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [1:0]                 op,
    input  logic [lcpe_pkg::WORD_W-1:0] led_word,
    output logic                       push,
    output lcpe_pkg::desc_t            push_desc
);

    logic [lcpe_pkg::WORD_W-1:0] saved_word_reg;
    logic [lcpe_pkg::WORD_W-1:0] saved_word_next;
    logic [lcpe_pkg::WORD_W-1:0] src_word;
    logic [lcpe_pkg::DIGIT_COUNT-1:0] en_bits;

    always_comb begin
        saved_word_next = saved_word_reg;
        push            = 1'b0;
        src_word        = saved_word_reg;
        push_desc       = '0;
        case (lcpe_pkg::op_t'(op))
            lcpe_pkg::OP_INIT: begin
                push                = accept;
                push_desc.init_left = 1'b1;
                push_desc.hdr_left  = lcpe_pkg::HDR_NONE;
            end
            lcpe_pkg::OP_SET: begin
                push               = accept;
                src_word           = led_word;
                push_desc.hdr_left = lcpe_pkg::HDR_USER;
                if (accept) begin
                    saved_word_next = led_word;
                end
            end
            lcpe_pkg::OP_REPLAY: begin
                push                = accept;
                push_desc.init_left = 1'b1;
                push_desc.hdr_left  = lcpe_pkg::HDR_USER;
            end
            default: begin
                // Unused code: taken and dropped.
                push = 1'b0;
            end
        endcase
        en_bits = src_word[lcpe_pkg::EN_LSB +: lcpe_pkg::DIGIT_COUNT];
        push_desc.en     = en_bits;
        push_desc.points = src_word[lcpe_pkg::DP_LSB +: lcpe_pkg::DIGIT_COUNT];
        push_desc.digits = src_word[lcpe_pkg::DIGITS_W-1:0];
        if (push_desc.hdr_left != lcpe_pkg::HDR_NONE) begin
            push_desc.dig_left = en_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saved_word_reg <= '0;
        end else begin
            saved_word_reg <= saved_word_next;
        end
    end

endmodule

>>> sv/lcpe_queue.sv
// Short descriptor queue between the front and back ends.
module lcpe_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lcpe_pkg::desc_t      push_desc,
    input  logic                 pop,
    output lcpe_pkg::desc_t      head_desc,
    output lcpe_pkg::q_status_t  status
);

    lcpe_pkg::desc_t                mem_reg [lcpe_pkg::QUEUE_DEPTH];
    logic [lcpe_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lcpe_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lcpe_pkg::QCNT_W-1:0]    count_reg, count_next;

    localparam logic [lcpe_pkg::QPTR_W-1:0] PTR_LAST =
        lcpe_pkg::QPTR_W'(lcpe_pkg::QUEUE_DEPTH - 1);
    localparam logic [lcpe_pkg::QCNT_W-1:0] CNT_FULL =
        lcpe_pkg::QCNT_W'(lcpe_pkg::QUEUE_DEPTH);

    assign status.head_valid = (count_reg != '0);
    assign status.full       = (count_reg == CNT_FULL);
    assign head_desc         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/lcpe_back.sv
// Back end: holds opcode registers and sends one command byte per cycle when not stalled.
module lcpe_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lcpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcpe_pkg::BYTE_W-1:0]   cfg_wdata,
    input  lcpe_pkg::desc_t               head_desc,
    input  lcpe_pkg::q_status_t           q_status,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lcpe_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_last
);

    lcpe_pkg::cfg_regs_t cfg_reg;
    lcpe_pkg::desc_t     work_reg, work_next;
    logic                act_reg, act_next;
    logic                out_valid_reg, out_valid_next;
    logic [lcpe_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    lcpe_pkg::desc_t     cur;
    lcpe_pkg::desc_t     nxt;
    logic                have, out_free, fire, done;
    logic                found;
    logic [lcpe_pkg::NIB_W-1:0] nib;
    logic                pt;
    logic [lcpe_pkg::BYTE_W-1:0] byte_sel;

    always_comb begin
        cur      = act_reg ? work_reg : head_desc;
        have     = act_reg || q_status.head_valid;
        out_free = !out_valid_reg || m_ready;
        fire     = have && out_free;
        pop      = fire && !act_reg;

        nxt      = cur;
        found    = 1'b0;
        nib      = '0;
        pt       = 1'b0;
        byte_sel = '0;
        if (cur.init_left) begin
            byte_sel      = cfg_reg.init_opcode;
            nxt.init_left = 1'b0;
        end else if (cur.hdr_left == lcpe_pkg::HDR_USER) begin
            byte_sel     = cfg_reg.user_mode_opcode;
            nxt.hdr_left = lcpe_pkg::HDR_SET;
        end else if (cur.hdr_left == lcpe_pkg::HDR_SET) begin
            byte_sel     = cfg_reg.led_set_opcode;
            nxt.hdr_left = lcpe_pkg::HDR_MASK;
        end else if (cur.hdr_left == lcpe_pkg::HDR_MASK) begin
            byte_sel     = lcpe_pkg::BYTE_W'(cur.en);
            nxt.hdr_left = lcpe_pkg::HDR_NONE;
        end else begin
            // Lowest enabled digit still owed goes next.
            for (int i = 0; i < lcpe_pkg::DIGIT_COUNT; i++) begin
                if (cur.dig_left[i] && !found) begin
                    found          = 1'b1;
                    nib            = cur.digits[lcpe_pkg::NIB_W*i +: lcpe_pkg::NIB_W];
                    pt             = cur.points[i];
                    nxt.dig_left[i] = 1'b0;
                end
            end
            byte_sel = lcpe_pkg::seg_code(nib) | (pt ? lcpe_pkg::DP_FLAG : '0);
        end
        done = !nxt.init_left && (nxt.hdr_left == lcpe_pkg::HDR_NONE) &&
               (nxt.dig_left == '0);

        act_next       = act_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (fire) begin
            act_next       = !done;
            work_next      = nxt;
            out_valid_next = 1'b1;
            out_byte_next  = byte_sel;
            out_last_next  = done;
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lcpe_pkg::CFG_INIT_OPCODE:      cfg_reg.init_opcode      <= cfg_wdata;
                lcpe_pkg::CFG_USER_MODE_OPCODE: cfg_reg.user_mode_opcode <= cfg_wdata;
                lcpe_pkg::CFG_LED_SET_OPCODE:   cfg_reg.led_set_opcode   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        work_reg     <= work_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (!aresetn) begin
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = out_last_reg;

endmodule
